// ===== hdl/msd_pkg.sv =====
// Package for the motion stall detector: payload structs, field widths,
// configuration register indexes and input mode codes.
// No dependencies.
`default_nettype none

package msd_pkg;

    localparam int POS_BITS       = 24;
    localparam int SPEED_BITS     = 16;
    localparam int ELAPSED_BITS   = 16;
    localparam int MIN_MOVE_BITS  = 24;
    localparam int LIMIT_BITS     = 32;
    localparam int CMD_THR_BITS   = 15;
    localparam int STALL_MS_BITS  = 32;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 2;

    // Squared distances: the absolute difference of two positions fits POS_BITS.
    localparam int SQ_BITS   = 2 * POS_BITS;
    localparam int THR2_BITS = 2 * MIN_MOVE_BITS;

    localparam logic [STALL_MS_BITS-1:0] STALL_MS_MAX = '1;

    localparam logic [MIN_MOVE_BITS-1:0] MIN_MOVE_RESET    = MIN_MOVE_BITS'(100);
    localparam logic [LIMIT_BITS-1:0]    NO_PROG_LIM_RESET = LIMIT_BITS'(5000);
    localparam logic [LIMIT_BITS-1:0]    STUCK_LIM_RESET   = LIMIT_BITS'(3000);
    localparam logic [CMD_THR_BITS-1:0]  CMD_THR_RESET     = CMD_THR_BITS'(10);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MIN_MOVE          = 2'd0,
        REG_NO_PROGRESS_LIMIT = 2'd1,
        REG_STUCK_LIMIT       = 2'd2,
        REG_CMD_THRESHOLD     = 2'd3
    } cfg_reg_t;

    localparam logic MODE_UPDATE  = 1'b0;
    localparam logic MODE_RESTART = 1'b1;

    typedef struct packed {
        logic                           mode;
        logic                           sample_valid;
        logic signed [POS_BITS-1:0]     pos_x;
        logic signed [POS_BITS-1:0]     pos_y;
        logic signed [SPEED_BITS-1:0]   speed_cmd;
        logic        [ELAPSED_BITS-1:0] elapsed_ms;
    } in_item_t;

    typedef struct packed {
        logic                     anchored;
        logic                     no_progress;
        logic                     stuck;
        logic [STALL_MS_BITS-1:0] stall_ms;
    } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/motion_stall_detector.sv =====
// Motion stall detector top level: input register, combinational state update
// and result register. Depends on msd_pkg.
`default_nettype none

// The detector takes one sample transfer per cycle while the output side keeps
// up, and returns one result per sample through the input register and then the
// result register. Each sample is registered, then its squared distance from the
// anchor is compared with the squared progress threshold and the anchor, both
// stall timers and both flags are updated together; that update loop sets
// the rate of one sample per cycle. An input register and an output register
// separate the two sides, so a new sample is taken while a finished result
// still waits. Configuration writes take effect at once and are meant for idle
// periods only. TIMER_BITS sets the width of both saturating stall timers; the
// reported stall_ms is clamped to 32 bits.
module motion_stall_detector #(
    parameter int TIMER_BITS = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire msd_pkg::in_item_t                  in_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output msd_pkg::out_item_t                      out_data,
    input  wire logic                               cfg_write,
    input  wire logic [msd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [msd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import msd_pkg::*;

    localparam int CMP_W = (TIMER_BITS > LIMIT_BITS) ? TIMER_BITS : LIMIT_BITS;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

    // Configuration; the progress threshold is kept squared.
    logic [THR2_BITS-1:0]    thr2_reg;
    logic [LIMIT_BITS-1:0]   np_limit_reg;
    logic [LIMIT_BITS-1:0]   stuck_limit_reg;
    logic [CMD_THR_BITS-1:0] cmd_thr_reg;
    logic [MIN_MOVE_BITS-1:0] min_move_wr;

    // Detector state.
    logic signed [POS_BITS-1:0] anchor_x_reg, anchor_x_next;
    logic signed [POS_BITS-1:0] anchor_y_reg, anchor_y_next;
    logic                       has_anchor_reg, has_anchor_next;
    logic [TIMER_BITS-1:0]      stall_reg, stall_next;
    logic [TIMER_BITS-1:0]      cmd_stall_reg, cmd_stall_next;
    logic                       np_flag_reg, np_flag_next;
    logic                       stuck_flag_reg, stuck_flag_next;

    // Pipeline registers.
    logic      in_v_reg;
    in_item_t  in_item_reg;
    logic      out_v_reg;
    out_item_t out_item_reg;
    out_item_t result;
    logic      advance;

    // Datapath.
    logic [POS_BITS:0]     diff_x, diff_y;
    logic [POS_BITS-1:0]   abs_x, abs_y;
    logic [SQ_BITS-1:0]    sq_x, sq_y;
    logic [SQ_BITS:0]      dist2;
    logic                  moved;
    logic                  commanding;
    logic [TIMER_BITS:0]   stall_sum, cmd_sum;
    logic [TIMER_BITS-1:0] stall_inc, cmd_inc;
    logic [CMP_W-1:0]      stall_ext;

    assign advance   = in_v_reg && (!out_v_reg || out_ready);
    assign in_ready  = !in_v_reg || advance;
    assign out_valid = out_v_reg;
    assign out_data  = out_item_reg;

    assign min_move_wr = cfg_data[MIN_MOVE_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr2_reg        <= THR2_BITS'(MIN_MOVE_RESET) * THR2_BITS'(MIN_MOVE_RESET);
            np_limit_reg    <= NO_PROG_LIM_RESET;
            stuck_limit_reg <= STUCK_LIM_RESET;
            cmd_thr_reg     <= CMD_THR_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MIN_MOVE:
                    thr2_reg <= THR2_BITS'(min_move_wr) * THR2_BITS'(min_move_wr);
                REG_NO_PROGRESS_LIMIT: np_limit_reg    <= cfg_data[LIMIT_BITS-1:0];
                REG_STUCK_LIMIT:       stuck_limit_reg <= cfg_data[LIMIT_BITS-1:0];
                REG_CMD_THRESHOLD:     cmd_thr_reg     <= cfg_data[CMD_THR_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Distance from the anchor, squared.
    always_comb
    begin
        diff_x = {in_item_reg.pos_x[POS_BITS-1], in_item_reg.pos_x}
               - {anchor_x_reg[POS_BITS-1], anchor_x_reg};
        diff_y = {in_item_reg.pos_y[POS_BITS-1], in_item_reg.pos_y}
               - {anchor_y_reg[POS_BITS-1], anchor_y_reg};
        abs_x  = diff_x[POS_BITS] ? POS_BITS'(-diff_x) : diff_x[POS_BITS-1:0];
        abs_y  = diff_y[POS_BITS] ? POS_BITS'(-diff_y) : diff_y[POS_BITS-1:0];
        sq_x   = SQ_BITS'(abs_x) * SQ_BITS'(abs_x);
        sq_y   = SQ_BITS'(abs_y) * SQ_BITS'(abs_y);
        dist2  = {1'b0, sq_x} + {1'b0, sq_y};
        moved  = dist2 >= (SQ_BITS + 1)'(thr2_reg);
    end

    // Saturating timer increments.
    always_comb
    begin
        stall_sum  = {1'b0, stall_reg} + (TIMER_BITS + 1)'(in_item_reg.elapsed_ms);
        cmd_sum    = {1'b0, cmd_stall_reg} + (TIMER_BITS + 1)'(in_item_reg.elapsed_ms);
        stall_inc  = stall_sum[TIMER_BITS] ? TIMER_MAX : stall_sum[TIMER_BITS-1:0];
        cmd_inc    = cmd_sum[TIMER_BITS] ? TIMER_MAX : cmd_sum[TIMER_BITS-1:0];
        commanding = !in_item_reg.speed_cmd[SPEED_BITS-1]
                  && (in_item_reg.speed_cmd[SPEED_BITS-2:0] > cmd_thr_reg);
    end

    always_comb
    begin
        anchor_x_next   = anchor_x_reg;
        anchor_y_next   = anchor_y_reg;
        has_anchor_next = has_anchor_reg;
        stall_next      = stall_reg;
        cmd_stall_next  = cmd_stall_reg;
        np_flag_next    = np_flag_reg;
        stuck_flag_next = stuck_flag_reg;
        priority if (in_item_reg.mode == MODE_RESTART)
        begin
            anchor_x_next   = '0;
            anchor_y_next   = '0;
            has_anchor_next = 1'b0;
            stall_next      = '0;
            cmd_stall_next  = '0;
            np_flag_next    = 1'b0;
            stuck_flag_next = 1'b0;
        end
        else if (in_item_reg.sample_valid)
        begin
            // The first sample, or a real move, re-anchors and clears progress.
            if (!has_anchor_reg || moved)
            begin
                anchor_x_next   = in_item_reg.pos_x;
                anchor_y_next   = in_item_reg.pos_y;
                has_anchor_next = 1'b1;
                stall_next      = '0;
                cmd_stall_next  = '0;
                np_flag_next    = 1'b0;
                stuck_flag_next = 1'b0;
            end
            else
            begin
                stall_next   = stall_inc;
                np_flag_next = CMP_W'(stall_inc) >= CMP_W'(np_limit_reg);
                if (commanding)
                begin
                    cmd_stall_next  = cmd_inc;
                    stuck_flag_next = CMP_W'(cmd_inc) >= CMP_W'(stuck_limit_reg);
                end
                else
                begin
                    cmd_stall_next  = '0;
                    stuck_flag_next = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        stall_ext          = CMP_W'(stall_next);
        result.anchored    = has_anchor_next;
        result.no_progress = np_flag_next;
        result.stuck       = stuck_flag_next;
        result.stall_ms    = (stall_ext > CMP_W'(STALL_MS_MAX)) ? STALL_MS_MAX
                                                                : stall_ext[STALL_MS_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_x_reg   <= '0;
            anchor_y_reg   <= '0;
            has_anchor_reg <= 1'b0;
            stall_reg      <= '0;
            cmd_stall_reg  <= '0;
            np_flag_reg    <= 1'b0;
            stuck_flag_reg <= 1'b0;
            in_v_reg       <= 1'b0;
            out_v_reg      <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_v_reg <= in_valid;
            end
            if (advance)
            begin
                anchor_x_reg   <= anchor_x_next;
                anchor_y_reg   <= anchor_y_next;
                has_anchor_reg <= has_anchor_next;
                stall_reg      <= stall_next;
                cmd_stall_reg  <= cmd_stall_next;
                np_flag_reg    <= np_flag_next;
                stuck_flag_reg <= stuck_flag_next;
                out_v_reg      <= 1'b1;
            end
            else if (out_ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/msd_checker.sv =====
// Port-level checks for the motion stall detector, bound to the top level.
// Depends on msd_pkg and motion_stall_detector.
`default_nettype none

module msd_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire msd_pkg::in_item_t  in_data,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire msd_pkg::out_item_t out_data
);
    import msd_pkg::*;

    // A result that is not taken stays, unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    // Flags can only be raised once an anchor is held.
    a_flags_need_anchor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.anchored |->
            !out_data.no_progress && !out_data.stuck && out_data.stall_ms == '0)
        else $error("stall state reported without an anchor");

    // A restart sample taken into an empty pipeline reports a cleared state.
    // The output staying empty in the following cycle after the transfer shows that no
    // earlier sample was still waiting in the input register.
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.mode == MODE_RESTART && !out_valid) ##1 !out_valid
            |=> out_valid && !out_data.anchored)
        else $error("restart did not clear the anchor");

    // The input side never takes a transfer while the output side holds a
    // stalled result and the previous sample is still waiting.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && $past(in_valid && in_ready) && $past(out_valid && !out_ready)
            |-> !in_ready)
        else $error("input taken with both stages full");

endmodule

bind motion_stall_detector msd_checker u_msd_checker (.*);

`default_nettype wire

// ===== tb/sv/motion_stall_detector_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for motion_stall_detector: directed and random position
// samples, a status predictor and a result checker. Depends on msd_pkg and the RTL.
module motion_stall_detector_tb;
    import msd_pkg::*;

    localparam int     TMR_BITS = 32;
    localparam longint POS_MAX  = 8388607;
    localparam longint POS_MIN  = -8388608;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    in_item_t                  in_data   = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    out_item_t                 out_data;
    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_MIN_MOVE;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    // Predictor copy of the settings and of the detector state.
    logic [MIN_MOVE_BITS-1:0] min_move          = MIN_MOVE_RESET;
    logic [LIMIT_BITS-1:0]    no_progress_limit = NO_PROG_LIM_RESET;
    logic [LIMIT_BITS-1:0]    stuck_limit       = STUCK_LIM_RESET;
    logic [CMD_THR_BITS-1:0]  cmd_threshold     = CMD_THR_RESET;
    longint                   anchor_x          = 0;
    longint                   anchor_y          = 0;
    bit                       has_anchor        = 1'b0;
    bit                       no_progress_flag  = 1'b0;
    bit                       stuck_flag        = 1'b0;
    logic [TMR_BITS-1:0]      stall_timer       = '0;
    logic [TMR_BITS-1:0]      cmd_stall_timer   = '0;

    in_item_t  samples_to_send[$];
    out_item_t status_due[$];
    longint    walk_x       = 0;
    longint    walk_y       = 0;
    bit        gaps_on      = 1'b1;
    int        mismatches   = 0;
    int        results_seen = 0;

    motion_stall_detector #(
        .TIMER_BITS(TMR_BITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [TMR_BITS-1:0] timer_add(input logic [TMR_BITS-1:0] t,
                                                      input logic [ELAPSED_BITS-1:0] d);
        logic [TMR_BITS:0] sum;
        sum = t + d;
        return sum[TMR_BITS] ? '1 : sum[TMR_BITS-1:0];
    endfunction

    function automatic void clear_timers();
        stall_timer      = '0;
        cmd_stall_timer  = '0;
        no_progress_flag = 1'b0;
        stuck_flag       = 1'b0;
    endfunction

    function automatic out_item_t track_sample(input in_item_t s);
        longint          px;
        longint          py;
        longint          dx;
        longint          dy;
        longint          spd;
        longint unsigned dist2;
        longint unsigned thr2;
        out_item_t       r;
        px  = $signed(s.pos_x);
        py  = $signed(s.pos_y);
        spd = $signed(s.speed_cmd);
        if (s.mode == MODE_RESTART)
        begin
            anchor_x   = 0;
            anchor_y   = 0;
            has_anchor = 1'b0;
            clear_timers();
        end
        else if (s.sample_valid)
        begin
            if (!has_anchor)
            begin
                anchor_x   = px;
                anchor_y   = py;
                has_anchor = 1'b1;
                clear_timers();
            end
            else
            begin
                dx = px - anchor_x;
                dy = py - anchor_y;
                if (dx < 0)
                    dx = -dx;
                if (dy < 0)
                    dy = -dy;
                // Compared as squares, so a move of exactly the threshold counts.
                dist2 = dx * dx + dy * dy;
                thr2  = longint'(min_move) * longint'(min_move);
                if (dist2 >= thr2)
                begin
                    anchor_x = px;
                    anchor_y = py;
                    clear_timers();
                end
                else
                begin
                    stall_timer      = timer_add(stall_timer, s.elapsed_ms);
                    no_progress_flag = (stall_timer >= no_progress_limit);
                    if (spd > longint'(cmd_threshold))
                    begin
                        cmd_stall_timer = timer_add(cmd_stall_timer, s.elapsed_ms);
                        stuck_flag      = (cmd_stall_timer >= stuck_limit);
                    end
                    else
                    begin
                        cmd_stall_timer = '0;
                        stuck_flag      = 1'b0;
                    end
                end
            end
        end
        r.anchored    = has_anchor;
        r.no_progress = no_progress_flag;
        r.stuck       = stuck_flag;
        r.stall_ms    = stall_timer;
        return r;
    endfunction

    function automatic longint bound_pos(input longint v);
        if (v > POS_MAX)
            return POS_MAX;
        if (v < POS_MIN)
            return POS_MIN;
        return v;
    endfunction

    function automatic longint rand_pos();
        return longint'($urandom_range(24'hFF_FFFF)) + POS_MIN;
    endfunction

    function automatic in_item_t make_sample(input logic mode, input logic valid,
                                             input longint x, input longint y,
                                             input int spd, input int dt);
        in_item_t s;
        s.mode         = mode;
        s.sample_valid = valid;
        s.pos_x        = x[POS_BITS-1:0];
        s.pos_y        = y[POS_BITS-1:0];
        s.speed_cmd    = spd[SPEED_BITS-1:0];
        s.elapsed_ms   = dt[ELAPSED_BITS-1:0];
        return s;
    endfunction

    function automatic int pick_speed();
        int thr;
        int r;
        int v;
        thr = cmd_threshold;
        r   = $urandom_range(99);
        if (r < 55)
        begin
            v = thr + 1 + int'($urandom_range(40));
            return (v > 32767) ? 32767 : v;
        end
        if (r < 80)
            return thr - int'($urandom_range(100));
        return int'($urandom_range(65535)) - 32768;
    endfunction

    function automatic int pick_elapsed();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return $urandom_range(3000);
        if (r < 85)
            return $urandom_range(65535);
        return $urandom_range(20);
    endfunction

    function automatic logic [31:0] pick_setting(input cfg_reg_t idx);
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return '0;
        // Full random data also exercises the bits above each register's width.
        if (r < 35)
            return $urandom;
        case (idx)
            REG_MIN_MOVE:      return (r < 50) ? 32'h00FF_FFFF : $urandom_range(2000, 1);
            REG_CMD_THRESHOLD: return (r < 50) ? 32'h0000_7FFF : $urandom_range(500, 1);
            default:           return (r < 50) ? 32'hFFFF_FFFF : $urandom_range(60000, 1);
        endcase
    endfunction

    // Mostly a walk that lingers near the last jump target so the stall timers
    // build up, with occasional jumps, restarts, unusable samples and noise.
    function automatic in_item_t next_walk_sample();
        int     r;
        longint reach;
        longint nx;
        longint ny;
        r = $urandom_range(99);
        if (r < 3)
            return make_sample(MODE_RESTART, 1'($urandom_range(1)), rand_pos(), rand_pos(),
                               $urandom_range(65535), $urandom_range(65535));
        if (r < 8)
            return make_sample(MODE_UPDATE, 1'b0, rand_pos(), rand_pos(),
                               $urandom_range(65535), $urandom_range(65535));
        if (r < 13)
            return make_sample(MODE_UPDATE, 1'b1, rand_pos(), rand_pos(),
                               pick_speed(), pick_elapsed());
        reach = (r < 25) ? 2 * longint'(min_move) + 2 : longint'(min_move) / 2;
        if (reach > POS_MAX)
            reach = POS_MAX;
        nx = bound_pos(walk_x + longint'($urandom_range(32'(2 * reach))) - reach);
        ny = bound_pos(walk_y + longint'($urandom_range(32'(2 * reach))) - reach);
        if (r < 25)
        begin
            walk_x = nx;
            walk_y = ny;
        end
        return make_sample(MODE_UPDATE, 1'b1, nx, ny, pick_speed(), pick_elapsed());
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 50)
            $display("[%0t] status %0d: %s", $time, results_seen, what);
    endtask

    task automatic check_status(input out_item_t got);
        out_item_t want;
        results_seen++;
        if (status_due.size() == 0)
        begin
            report_mismatch("status transfer with no sample outstanding");
            return;
        end
        want = status_due.pop_front();
        if (got.anchored !== want.anchored)
            report_mismatch($sformatf("anchored %0b, expected %0b", got.anchored,
                                      want.anchored));
        if (got.no_progress !== want.no_progress)
            report_mismatch($sformatf("no_progress %0b, expected %0b", got.no_progress,
                                      want.no_progress));
        if (got.stuck !== want.stuck)
            report_mismatch($sformatf("stuck %0b, expected %0b", got.stuck, want.stuck));
        if (got.stall_ms !== want.stall_ms)
            report_mismatch($sformatf("stall_ms %0d, expected %0d", got.stall_ms,
                                      want.stall_ms));
    endtask

    // Sample driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                status_due.push_back(track_sample(in_data));
            if (!in_valid || in_ready)
            begin
                if (samples_to_send.size() != 0 && !(gaps_on && $urandom_range(99) < 11))
                begin
                    in_data  <= samples_to_send.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Status monitor.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_status(out_data);
            out_ready <= !(gaps_on && $urandom_range(99) < 11);
        end
    end

    // Registers are only written once every sample has come back as a status.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (samples_to_send.size() != 0 || in_valid || status_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_MIN_MOVE:          min_move          = value[MIN_MOVE_BITS-1:0];
            REG_NO_PROGRESS_LIMIT: no_progress_limit = value[LIMIT_BITS-1:0];
            REG_STUCK_LIMIT:       stuck_limit       = value[LIMIT_BITS-1:0];
            REG_CMD_THRESHOLD:     cmd_threshold     = value[CMD_THR_BITS-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic configure(input logic [31:0] move, input logic [31:0] np_lim,
                             input logic [31:0] st_lim, input logic [31:0] thr);
        wait_drained();
        write_reg(REG_MIN_MOVE, move);
        write_reg(REG_NO_PROGRESS_LIMIT, np_lim);
        write_reg(REG_STUCK_LIMIT, st_lim);
        write_reg(REG_CMD_THRESHOLD, thr);
        @(negedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Settings after reset: threshold 100 mm, limits 5000 and 3000 ms, speed 10.
        samples_to_send.push_back(make_sample(MODE_UPDATE, 1'b0, POS_MAX, POS_MIN, 32767, 65535));
        samples_to_send.push_back(make_sample(MODE_UPDATE, 1'b1, 0, 0, 0, 0));
        samples_to_send.push_back(make_sample(MODE_UPDATE, 1'b1, 3, 4, 11, 4999));
        samples_to_send.push_back(make_sample(MODE_UPDATE, 1'b1, -3, -4, 11, 1));
        samples_to_send.push_back(make_sample(MODE_UPDATE, 1'b1, 0, 99, 10, 0));
        samples_to_send.push_back(make_sample(MODE_UPDATE, 1'b1, 50, 50, -32768, 65535));
        samples_to_send.push_back(make_sample(MODE_UPDATE, 1'b0, POS_MAX, POS_MAX, 100, 9));
        samples_to_send.push_back(make_sample(MODE_UPDATE, 1'b1, 60, 80, 20, 7));
        samples_to_send.push_back(make_sample(MODE_UPDATE, 1'b1, 130, 151, 20, 7));
        samples_to_send.push_back(make_sample(MODE_UPDATE, 1'b1, POS_MAX, POS_MAX, 0, 1));
        samples_to_send.push_back(make_sample(MODE_UPDATE, 1'b1, POS_MIN, POS_MIN, 0, 1));
        samples_to_send.push_back(make_sample(MODE_UPDATE, 1'b1, POS_MIN, POS_MAX, 0, 1));
        samples_to_send.push_back(make_sample(MODE_RESTART, 1'b0, 17, -17, 300, 300));
        samples_to_send.push_back(make_sample(MODE_RESTART, 1'b1, POS_MAX, POS_MIN, 32767, 65535));
        samples_to_send.push_back(make_sample(MODE_UPDATE, 1'b0, 5, 5, 50, 50));
        samples_to_send.push_back(make_sample(MODE_UPDATE, 1'b1, POS_MIN, POS_MAX, 32767, 65535));
        samples_to_send.push_back(make_sample(MODE_UPDATE, 1'b1, POS_MIN, POS_MAX, 32767, 65535));
        samples_to_send.push_back(make_sample(MODE_UPDATE, 1'b1, POS_MIN, POS_MAX, 0, 0));
        samples_to_send.push_back(make_sample(MODE_RESTART, 1'b0, 0, 0, 0, 0));

        // Zero limits and zero speed threshold: flags rise on the first stalled sample.
        configure(50, 0, 0, 0);
        samples_to_send.push_back(make_sample(MODE_UPDATE, 1'b1, 100, -100, 1, 0));
        samples_to_send.push_back(make_sample(MODE_UPDATE, 1'b1, 100, -100, 1, 0));
        samples_to_send.push_back(make_sample(MODE_UPDATE, 1'b1, 130, -60, 0, 3));
        samples_to_send.push_back(make_sample(MODE_UPDATE, 1'b1, 130, -60, -1, 0));

        // Zero distance threshold: every usable sample moves the anchor.
        configure(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        samples_to_send.push_back(make_sample(MODE_UPDATE, 1'b1, 130, -60, 32767, 65535));
        samples_to_send.push_back(make_sample(MODE_UPDATE, 1'b1, -5, 7, 32767, 65535));

        // Long stall: the largest threshold keeps every sample stalled, so both
        // timers climb in large steps.
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 0);
        for (int k = 0; k < 100; k++)
            samples_to_send.push_back(make_sample(MODE_UPDATE, 1'b1,
                -5 + longint'($urandom_range(2000)) - 1000,
                7 + longint'($urandom_range(2000)) - 1000,
                1 + int'($urandom_range(32766)), 65535));

        for (int ph = 0; ph < 5; ph++)
        begin
            configure(pick_setting(REG_MIN_MOVE), pick_setting(REG_NO_PROGRESS_LIMIT),
                      pick_setting(REG_STUCK_LIMIT), pick_setting(REG_CMD_THRESHOLD));
            gaps_on = (ph != 2);
            for (int k = 0; k < 320; k++)
                samples_to_send.push_back(next_walk_sample());
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("motion_stall_detector_tb OK");
        else
            $display("motion_stall_detector_tb NOT OK");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("motion_stall_detector_tb NOT OK");
        $finish;
    end

endmodule
